>>> rtl/fpml_pkg.sv
// Package for the FDTD PML cell update core: field and coefficient widths,
// function codes, transaction payload types and the saturation helpers.
// No dependencies.
package fpml_pkg;

   localparam int FIELD_W   = 32;              // Q16.16 field word
   localparam int COEF_W    = 18;              // unsigned Q2.16 coefficient
   localparam int COEF_FRAC = COEF_W - 2;
   localparam int DIFF_W    = FIELD_W + 1;     // exact difference of two fields
   localparam int SCALED_W  = DIFF_W + 3;      // floor(diff * coef / 2^COEF_FRAC)
   localparam int SUM_W     = SCALED_W + 1;    // sum of two scaled terms

   localparam logic [1:0] FUNC_INTERIOR = 2'd0;
   localparam logic [1:0] FUNC_PML      = 2'd1;
   localparam logic [1:0] FUNC_MATERIAL = 2'd2;
   localparam logic [1:0] FUNC_PASS     = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [FIELD_W-1:0] first_upper;
      logic [FIELD_W-1:0] first_lower;
      logic [FIELD_W-1:0] second_upper;
      logic [FIELD_W-1:0] second_lower;
      logic [COEF_W-1:0]  first_step_coef;
      logic [COEF_W-1:0]  second_step_coef;
      logic [FIELD_W-1:0] old_value;
      logic [COEF_W-1:0]  decay_coef;
      logic [COEF_W-1:0]  gain_coef;
      logic [COEF_W-1:0]  integ_coef;
      logic [FIELD_W-1:0] accum_in;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] new_value;
      logic [FIELD_W-1:0] new_accum;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic               clip;
   } sat_type;

   function automatic logic signed [SUM_W-1:0] ext_field(input logic [FIELD_W-1:0] x);
      ext_field = $signed({{(SUM_W-FIELD_W){x[FIELD_W-1]}}, x});
   endfunction

   function automatic logic signed [SUM_W-1:0] ext_scaled(input logic [SCALED_W-1:0] x);
      ext_scaled = $signed({{(SUM_W-SCALED_W){x[SCALED_W-1]}}, x});
   endfunction

   function automatic logic signed [DIFF_W-1:0] ext_diff(input logic [FIELD_W-1:0] x);
      ext_diff = $signed({x[FIELD_W-1], x});
   endfunction

   // clip a wide signed value to the field range
   function automatic sat_type sat_field(input logic [SUM_W-1:0] x);
      logic [SUM_W-FIELD_W:0] upper;
      sat_type                r;
      upper = x[SUM_W-1:FIELD_W-1];
      if (upper == '0 || upper == '1) begin
         r.value = x[FIELD_W-1:0];
         r.clip  = 1'b0;
      end else if (x[SUM_W-1]) begin
         r.value = {1'b1, {(FIELD_W-1){1'b0}}};
         r.clip  = 1'b1;
      end else begin
         r.value = {1'b0, {(FIELD_W-1){1'b1}}};
         r.clip  = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> rtl/fpml_coef_mul.sv
// Registered signed-by-unsigned coefficient multiplier with floor scaling.
// Depends on fpml_pkg for default widths.
module fpml_coef_mul
   import fpml_pkg::*;
#(
   parameter int VALUE_WIDTH = DIFF_W,
   parameter int COEF_WIDTH  = COEF_W
) (
   input  logic                                 clock,
   input  logic signed [VALUE_WIDTH-1:0]        value_in,
   input  logic        [COEF_WIDTH-1:0]         coef_in,
   output logic signed [VALUE_WIDTH+2:0]        scaled_out
);

   localparam int PROD_W = VALUE_WIDTH + COEF_WIDTH + 1;
   localparam int FRAC   = COEF_WIDTH - 2;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   assign prod_in = value_in * $signed({1'b0, coef_in});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // dropping low bits of a two's complement word rounds toward minus infinity
   assign scaled_out = prod_ff[PROD_W-1:FRAC];

endmodule

>>> rtl/fdtd_pml_cell_update_core.sv
// Top level of the FDTD Yee cell update core with graded PML.
// Depends on fpml_pkg and fpml_coef_mul.
//
// One cell update per clock. A transaction is taken at every rising edge with
// start high and busy low; busy is high only while reset is asserted, so the
// core takes a new cell in every cycle. Each transaction produces exactly one
// result, shown on rsp_data with rsp_strobe high for one cycle, in acceptance
// order. The receiver cannot stall the core and must take every strobe. In the
// PML mode a cell passes through the chain: operand register, curl products,
// curl clip, integrator add, integrator product, drive add, gain product, final
// add, each a register stage of its own. Six multipliers run in parallel, one
// per product. func 3 passes the cell through.
module fdtd_pml_cell_update_core
   import fpml_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // fields carried down the pipeline alongside the products
   typedef struct packed {
      logic [1:0]          func;
      logic [FIELD_W-1:0]  old_value;
      logic [FIELD_W-1:0]  accum;
      logic [COEF_W-1:0]   gain;
      logic [COEF_W-1:0]   integ;
      logic [FIELD_W-1:0]  curl;
      logic [FIELD_W-1:0]  e_value;
      logic [FIELD_W-1:0]  a_value;
      logic [FIELD_W-1:0]  drive;
      logic [FIELD_W-1:0]  accum_out;
      logic [SCALED_W-1:0] decay_term;
      logic                clip;
   } carry_type;

   logic accept;

   // stage valid bits: a b c d e f g, then the output strobe
   logic [6:0] valid_ff;
   logic       strobe_ff;

   // stage A: differences and multiplier operands
   logic signed [DIFF_W-1:0] d1_ff, d2_ff, dd_ff, old_ext_ff;
   logic        [COEF_W-1:0] c1_ff, c2_ff, decay_ff;
   carry_type                carry_a_in, carry_a_ff;

   // stage B products
   logic signed [SCALED_W-1:0] p1, p2, pold, pe;
   carry_type                  carry_b_ff;

   carry_type carry_c_in, carry_c_ff;
   carry_type carry_d_in, carry_d_ff;

   // stage E integrator product
   logic signed [DIFF_W-1:0]   integ_opnd;
   logic signed [SCALED_W-1:0] pi;
   carry_type                  carry_e_ff;

   carry_type carry_f_in, carry_f_ff;

   // stage G gain product
   logic signed [SCALED_W-1:0] pg;
   carry_type                  carry_g_ff;

   rsp_type rsp_in, rsp_ff;

   sat_type curl_sat, e_sat, a_sat, t_sat, n_sat, v_sat;

   assign busy   = reset;
   assign accept = start && !busy;

   // ---------------- stage A: register operands, form differences
   always_comb begin
      carry_a_in           = '0;
      carry_a_in.func      = req_data.func;
      carry_a_in.old_value = req_data.old_value;
      carry_a_in.accum     = req_data.accum_in;
      carry_a_in.gain      = req_data.gain_coef;
      carry_a_in.integ     = req_data.integ_coef;
   end

   always_ff @(posedge clock) begin
      d1_ff      <= ext_diff(req_data.first_upper) - ext_diff(req_data.first_lower);
      d2_ff      <= ext_diff(req_data.second_upper) - ext_diff(req_data.second_lower);
      dd_ff      <= ext_diff(req_data.old_value) - ext_diff(req_data.accum_in);
      old_ext_ff <= ext_diff(req_data.old_value);
      c1_ff      <= req_data.first_step_coef;
      c2_ff      <= req_data.second_step_coef;
      decay_ff   <= req_data.decay_coef;
      carry_a_ff <= carry_a_in;
   end

   // ---------------- stage B: curl, decay and material products
   fpml_coef_mul #(.VALUE_WIDTH(DIFF_W), .COEF_WIDTH(COEF_W)) u_mul_first (
      .clock(clock), .value_in(d1_ff), .coef_in(c1_ff), .scaled_out(p1));
   fpml_coef_mul #(.VALUE_WIDTH(DIFF_W), .COEF_WIDTH(COEF_W)) u_mul_second (
      .clock(clock), .value_in(d2_ff), .coef_in(c2_ff), .scaled_out(p2));
   fpml_coef_mul #(.VALUE_WIDTH(DIFF_W), .COEF_WIDTH(COEF_W)) u_mul_decay (
      .clock(clock), .value_in(old_ext_ff), .coef_in(decay_ff), .scaled_out(pold));
   fpml_coef_mul #(.VALUE_WIDTH(DIFF_W), .COEF_WIDTH(COEF_W)) u_mul_material (
      .clock(clock), .value_in(dd_ff), .coef_in(carry_a_ff.gain), .scaled_out(pe));

   always_ff @(posedge clock) begin
      carry_b_ff <= carry_a_ff;
   end

   // ---------------- stage C: clip curl and material E
   always_comb begin
      curl_sat              = sat_field(ext_scaled(p1) - ext_scaled(p2));
      e_sat                 = sat_field(ext_scaled(pe));
      carry_c_in            = carry_b_ff;
      carry_c_in.curl       = curl_sat.value;
      carry_c_in.e_value    = e_sat.value;
      carry_c_in.decay_term = pold;
      case (carry_b_ff.func) inside
         FUNC_INTERIOR, FUNC_PML: carry_c_in.clip = curl_sat.clip;
         FUNC_MATERIAL:           carry_c_in.clip = e_sat.clip;
         default:                 carry_c_in.clip = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      carry_c_ff <= carry_c_in;
   end

   // ---------------- stage D: PML integrator a = sat(accum + curl)
   always_comb begin
      a_sat              = sat_field(ext_field(carry_c_ff.accum) + ext_field(carry_c_ff.curl));
      carry_d_in         = carry_c_ff;
      carry_d_in.a_value = a_sat.value;
      if (carry_c_ff.func == FUNC_PML) begin
         carry_d_in.clip = carry_c_ff.clip | a_sat.clip;
      end
   end

   always_ff @(posedge clock) begin
      carry_d_ff <= carry_d_in;
   end

   // ---------------- stage E: integ times a (PML) or E (material)
   assign integ_opnd = (carry_d_ff.func == FUNC_PML) ? ext_diff(carry_d_ff.a_value)
                                                     : ext_diff(carry_d_ff.e_value);

   fpml_coef_mul #(.VALUE_WIDTH(DIFF_W), .COEF_WIDTH(COEF_W)) u_mul_integ (
      .clock(clock), .value_in(integ_opnd), .coef_in(carry_d_ff.integ), .scaled_out(pi));

   always_ff @(posedge clock) begin
      carry_e_ff <= carry_d_ff;
   end

   // ---------------- stage F: drive term and new integrator
   always_comb begin
      t_sat      = sat_field(ext_field(carry_e_ff.curl) + ext_scaled(pi));
      n_sat      = sat_field(ext_field(carry_e_ff.accum) + ext_scaled(pi));
      carry_f_in = carry_e_ff;
      case (carry_e_ff.func)
         FUNC_INTERIOR: begin
            carry_f_in.drive     = carry_e_ff.curl;
            carry_f_in.accum_out = carry_e_ff.accum;
         end
         FUNC_PML: begin
            carry_f_in.drive     = t_sat.value;
            carry_f_in.accum_out = carry_e_ff.a_value;
            carry_f_in.clip      = carry_e_ff.clip | t_sat.clip;
         end
         FUNC_MATERIAL: begin
            carry_f_in.drive     = carry_e_ff.curl;
            carry_f_in.accum_out = n_sat.value;
            carry_f_in.clip      = carry_e_ff.clip | n_sat.clip;
         end
         default: begin
            carry_f_in.drive     = carry_e_ff.curl;
            carry_f_in.accum_out = carry_e_ff.accum;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      carry_f_ff <= carry_f_in;
   end

   // ---------------- stage G: gain times drive
   fpml_coef_mul #(.VALUE_WIDTH(DIFF_W), .COEF_WIDTH(COEF_W)) u_mul_gain (
      .clock(clock), .value_in(ext_diff(carry_f_ff.drive)), .coef_in(carry_f_ff.gain),
      .scaled_out(pg));

   always_ff @(posedge clock) begin
      carry_g_ff <= carry_f_ff;
   end

   // ---------------- stage H: final sum (E or old value for material and pass), result register
   always_comb begin
      v_sat              = sat_field(ext_scaled(carry_g_ff.decay_term) + ext_scaled(pg));
      rsp_in.new_accum   = carry_g_ff.accum_out;
      rsp_in.saturated   = carry_g_ff.clip;
      case (carry_g_ff.func) inside
         FUNC_INTERIOR, FUNC_PML: begin
            rsp_in.new_value = v_sat.value;
            rsp_in.saturated = carry_g_ff.clip | v_sat.clip;
         end
         FUNC_MATERIAL: rsp_in.new_value = carry_g_ff.e_value;
         default:       rsp_in.new_value = carry_g_ff.old_value;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // valid bits travel with the data; nothing ever stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= {valid_ff[5:0], accept};
         strobe_ff <= valid_ff[6];
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // every accepted transaction returns its result strobe
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##8 rsp_strobe)
      else $error("result missing eight cycles after accept");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(reset, 8)) |-> $past(accept, 8))
      else $error("result without matching accept");

   // pass-through cells come back untouched and unflagged
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.func == FUNC_PASS) |-> ##8
      (rsp_data.new_value == $past(req_data.old_value, 8) && !rsp_data.saturated))
      else $error("pass-through cell modified");

   // interior and pass-through cells keep their integrator
   a_accum_kept: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FUNC_INTERIOR || req_data.func == FUNC_PASS)) |-> ##8
      (rsp_data.new_accum == $past(req_data.accum_in, 8)))
      else $error("integrator changed by a non-integrating function");
`endif

endmodule
